// ===== rtl/core/pwf_pkg.sv =====
// Shared widths, register indexes and arithmetic constants of the pixel write formatter.
// No dependencies; imported by the channel interfaces, the core, the checker and the testbench.
package pwf_pkg;

    localparam int PIX_X_W    = 11;
    localparam int PIX_Y_W    = 10;
    localparam int RGB_W      = 24;
    localparam int OFFSET_W   = 22;
    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 10;
    localparam int PITCH_W    = 13;
    localparam int LAYOUT_W   = 10;

    // Mask size is capped at this many bits.
    localparam int MAX_MASK   = 16;

    // floor(v/255) == (v * RECIP_255) >> 32 for every v below 255 * 2^16.
    localparam logic [24:0] RECIP_255 = 25'h1010102;
    localparam int          R255_SH   = 32;

    // floor(s/100) == (s * RECIP_100) >> 21 for every luma sum up to 25500.
    localparam logic [14:0] RECIP_100 = 15'd20972;
    localparam int          R100_SH   = 21;

    // Luma weights, in hundredths.
    localparam logic [14:0] LUMA_R = 15'd30;
    localparam logic [14:0] LUMA_G = 15'd59;
    localparam logic [14:0] LUMA_B = 15'd11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED      = 3'd0,
        CFG_FRAME_WIDTH  = 3'd1,
        CFG_FRAME_HEIGHT = 3'd2,
        CFG_LINE_PITCH   = 3'd3,
        CFG_BPP          = 3'd4,
        CFG_RED_LAYOUT   = 3'd5,
        CFG_GREEN_LAYOUT = 3'd6,
        CFG_BLUE_LAYOUT  = 3'd7
    } t_cfg_idx;

endpackage

// ===== rtl/core/pwf_pixel_if.sv =====
// Input channel of the pixel write formatter: one pixel write per item.
// Depends on pwf_pkg for field widths.
interface pwf_pixel_if;
    import pwf_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
    logic [RGB_W-1:0]   rgb_color;

    modport source (output valid, pixel_x, pixel_y, rgb_color, input ready);
    modport sink   (input valid, pixel_x, pixel_y, rgb_color, output ready);
endinterface

// ===== rtl/core/pwf_write_if.sv =====
// Output channel of the pixel write formatter: one frame-store write per item.
// Depends on pwf_pkg for field widths.
interface pwf_write_if;
    import pwf_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] byte_offset;
    logic [DATA_W-1:0]   write_data;
    logic [COUNT_W-1:0]  byte_count;

    modport source (output valid, byte_offset, write_data, byte_count, input ready);
    modport sink   (input valid, byte_offset, write_data, byte_count, output ready);
endinterface

// ===== rtl/core/pixel_write_formatter_core.sv =====
// Pixel write formatter: turns pixel writes into packed frame-store writes.
// Depends on pwf_pkg, pwf_pixel_if and pwf_write_if.
//
// Pipeline: 3 stages; an item moves through stages 1, 2 and 3 and is offered from stage 3.
// Throughput: 1 item per cycle while the output is not stalled.
// Stage 1 (range check, pitch multiply, channel pre-scale, luma sum), stage 2 (reciprocal
// multiplies for /255 and /100, offset add), stage 3 (field shifts, pack, mask or luma select).
// A stalled output freezes all three stages together; nothing is lost or repeated.
// Reset (synchronous, active low) clears the stage valid bits and loads the
// register defaults: disabled, 1x1 frame, pitch 1, 4 bytes/pixel, 8:8:8 layout.
module pixel_write_formatter_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 768,
    parameter int MAX_PITCH  = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pwf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pwf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pwf_pixel_if.sink                       i_pix,
    pwf_write_if.source                     o_wr
);
    import pwf_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                r_enabled;
    logic [WIDTH_W-1:0]  r_frame_width;
    logic [HEIGHT_W-1:0] r_frame_height;
    logic [PITCH_W-1:0]  r_line_pitch;
    logic [COUNT_W-1:0]  r_bpp;
    logic [LAYOUT_W-1:0] r_red_layout;
    logic [LAYOUT_W-1:0] r_green_layout;
    logic [LAYOUT_W-1:0] r_blue_layout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= 1'b0;
            r_frame_width  <= WIDTH_W'(1);
            r_frame_height <= HEIGHT_W'(1);
            r_line_pitch   <= PITCH_W'(1);
            r_bpp          <= COUNT_W'(4);
            r_red_layout   <= LAYOUT_W'(272);
            r_green_layout <= LAYOUT_W'(264);
            r_blue_layout  <= LAYOUT_W'(256);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLED:      r_enabled      <= i_cfg_data[0];
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[HEIGHT_W-1:0];
                CFG_LINE_PITCH:   r_line_pitch   <= i_cfg_data[PITCH_W-1:0];
                CFG_BPP:          r_bpp          <= i_cfg_data[COUNT_W-1:0];
                CFG_RED_LAYOUT:   r_red_layout   <= i_cfg_data[LAYOUT_W-1:0];
                CFG_GREEN_LAYOUT: r_green_layout <= i_cfg_data[LAYOUT_W-1:0];
                CFG_BLUE_LAYOUT:  r_blue_layout  <= i_cfg_data[LAYOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: one advance signal for the whole pipe
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid;
    logic adv;

    assign adv         = !r_s3_valid || o_wr.ready;
    assign i_pix.ready = adv;

    // ------------------------------------------------------------------
    // Stage 1 inputs: drop check, pitch multiply, luma sum, c*(2^n-1) per channel
    // ------------------------------------------------------------------
    logic                 bpp_ok;
    logic                 x_ok, y_ok;
    logic                 n_s1_valid;
    logic [PITCH_W-1:0]   pitch_eff;
    logic [OFFSET_W-1:0]  n_s1_yp;
    logic [7:0]           chan_r, chan_g, chan_b;
    logic [RGB_W-1:0]     n_s1_vr, n_s1_vg, n_s1_vb;
    logic [14:0]          n_s1_luma;

    // Mask size decode with the cap at MAX_MASK bits.
    function automatic logic [4:0] capped_mask_bits(input logic [LAYOUT_W-1:0] layout);
        logic [4:0] sz;
        sz = layout[9:5];
        return (sz > 5'(MAX_MASK)) ? 5'(MAX_MASK) : sz;
    endfunction

    // c * (2^n - 1) as (c << n) - c; n <= 16 keeps it inside 24 bits.
    function automatic logic [RGB_W-1:0] pre_scale(input logic [7:0] c,
                                                   input logic [LAYOUT_W-1:0] layout);
        logic [RGB_W-1:0] cw;
        cw = RGB_W'(c);
        return (cw << capped_mask_bits(layout)) - cw;
    endfunction

    assign chan_r = i_pix.rgb_color[23:16];
    assign chan_g = i_pix.rgb_color[15:8];
    assign chan_b = i_pix.rgb_color[7:0];

    always_comb begin
        bpp_ok     = r_bpp inside {[3'd1:3'd4]};
        // x < min(width, MAX_WIDTH) split into two compares
        x_ok       = (i_pix.pixel_x < r_frame_width) && (int'(i_pix.pixel_x) < MAX_WIDTH);
        y_ok       = (i_pix.pixel_y < r_frame_height) && (int'(i_pix.pixel_y) < MAX_HEIGHT);
        n_s1_valid = i_pix.valid && r_enabled && bpp_ok && x_ok && y_ok;
        // MAX_PITCH is only picked when it is below line_pitch, so it fits.
        pitch_eff  = (int'(r_line_pitch) > MAX_PITCH) ? PITCH_W'(MAX_PITCH) : r_line_pitch;
        n_s1_yp    = OFFSET_W'(i_pix.pixel_y * pitch_eff);
        n_s1_vr    = pre_scale(chan_r, r_red_layout);
        n_s1_vg    = pre_scale(chan_g, r_green_layout);
        n_s1_vb    = pre_scale(chan_b, r_blue_layout);
        n_s1_luma  = 15'(chan_r) * LUMA_R + 15'(chan_g) * LUMA_G + 15'(chan_b) * LUMA_B;
    end

    logic [PIX_X_W-1:0]  r_s1_x;
    logic [COUNT_W-1:0]  r_s1_bpp;
    logic [OFFSET_W-1:0] r_s1_yp;
    logic [RGB_W-1:0]    r_s1_vr, r_s1_vg, r_s1_vb;
    logic [14:0]         r_s1_luma;

    // ------------------------------------------------------------------
    // Stage 2 inputs: offset add, divide by 255 and 100 via reciprocal multiply
    // ------------------------------------------------------------------
    logic [48:0]         prod_r, prod_g, prod_b;
    logic [29:0]         prod_l;
    logic [15:0]         n_s2_qr, n_s2_qg, n_s2_qb;
    logic [7:0]          n_s2_luma;
    logic [OFFSET_W-1:0] n_s2_offset;

    always_comb begin
        prod_r      = 49'(r_s1_vr) * 49'(RECIP_255);
        prod_g      = 49'(r_s1_vg) * 49'(RECIP_255);
        prod_b      = 49'(r_s1_vb) * 49'(RECIP_255);
        prod_l      = 30'(r_s1_luma) * 30'(RECIP_100);
        n_s2_qr     = prod_r[R255_SH +: 16];
        n_s2_qg     = prod_g[R255_SH +: 16];
        n_s2_qb     = prod_b[R255_SH +: 16];
        n_s2_luma   = prod_l[R100_SH +: 8];
        // offset wraps at 2^22
        n_s2_offset = r_s1_yp + OFFSET_W'(r_s1_x * r_s1_bpp);
    end

    logic [15:0]         r_s2_qr, r_s2_qg, r_s2_qb;
    logic [7:0]          r_s2_luma;
    logic [OFFSET_W-1:0] r_s2_offset;
    logic [COUNT_W-1:0]  r_s2_bpp;

    // ------------------------------------------------------------------
    // Stage 3 inputs: place fields, pack, pick luma and trim to the pixel size
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] packed_rgb;
    logic [DATA_W-1:0] n_s3_data;

    always_comb begin
        // bits shifted past bit 31 fall off
        packed_rgb = (DATA_W'(r_s2_qr) << r_red_layout[4:0])
                   | (DATA_W'(r_s2_qg) << r_green_layout[4:0])
                   | (DATA_W'(r_s2_qb) << r_blue_layout[4:0]);
        case (r_s2_bpp)
            3'd1:    n_s3_data = DATA_W'(r_s2_luma);
            3'd2:    n_s3_data = packed_rgb & 32'h0000_FFFF;
            3'd3:    n_s3_data = packed_rgb & 32'h00FF_FFFF;
            default: n_s3_data = packed_rgb;
        endcase
    end

    logic [OFFSET_W-1:0] r_s3_offset;
    logic [DATA_W-1:0]   r_s3_data;
    logic [COUNT_W-1:0]  r_s3_bpp;

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_x      <= i_pix.pixel_x;
            r_s1_bpp    <= r_bpp;
            r_s1_yp     <= n_s1_yp;
            r_s1_vr     <= n_s1_vr;
            r_s1_vg     <= n_s1_vg;
            r_s1_vb     <= n_s1_vb;
            r_s1_luma   <= n_s1_luma;

            r_s2_qr     <= n_s2_qr;
            r_s2_qg     <= n_s2_qg;
            r_s2_qb     <= n_s2_qb;
            r_s2_luma   <= n_s2_luma;
            r_s2_offset <= n_s2_offset;
            r_s2_bpp    <= r_s1_bpp;

            r_s3_offset <= r_s2_offset;
            r_s3_data   <= n_s3_data;
            r_s3_bpp    <= r_s2_bpp;
        end
    end

    assign o_wr.valid       = r_s3_valid;
    assign o_wr.byte_offset = r_s3_offset;
    assign o_wr.write_data  = r_s3_data;
    assign o_wr.byte_count  = r_s3_bpp;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_s1_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(adv) && r_s1_valid |-> $past(i_pix.valid && r_enabled))
        else $error("stage 1 valid without an accepted enabled item");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.valid |-> (o_wr.byte_count != 3'd0) && (o_wr.byte_count <= 3'd4))
        else $error("byte count out of range");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.valid && (o_wr.byte_count == 3'd1) |-> (o_wr.write_data[31:8] == 24'd0))
        else $error("grey pixel has bits above byte 0");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !adv |=> $stable(r_s1_valid) && $stable(r_s2_valid)
                            && $stable(r_s3_offset))
        else $error("pipeline moved during a stall");

endmodule

// ===== verif/pwf_write_checker.sv =====
// Checker for the pixel write formatter: watches the pixel, write and config ports,
// predicts each frame-store write and compares it. Depends on pwf_pkg and the channel ifs.
`timescale 1ns / 100ps

module pwf_write_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 768,
    parameter int MAX_PITCH  = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pwf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pwf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pwf_pixel_if                           i_pix,
    pwf_write_if                           i_wr,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_writes_checked
);
    import pwf_pkg::*;

    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [DATA_W-1:0]   write_data;
        logic [COUNT_W-1:0]  byte_count;
    } t_frame_write;

    // local copy of the register file
    logic                cfg_enabled;
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;
    logic [PITCH_W-1:0]  cfg_pitch;
    logic [COUNT_W-1:0]  cfg_bpp;
    logic [LAYOUT_W-1:0] cfg_red, cfg_green, cfg_blue;

    t_frame_write expected_writes[$];
    t_frame_write want, got, pred;
    int           fail_count     = 0;
    int           writes_checked = 0;

    // scale one 8-bit channel to its mask size and move it to its field position
    function automatic logic [DATA_W-1:0] place_channel(input logic [7:0] chan,
                                                         input logic [LAYOUT_W-1:0] layout);
        logic [4:0]  pos;
        logic [4:0]  size;
        logic [31:0] top_val;
        logic [31:0] scaled;
        pos  = layout[4:0];
        size = layout[9:5];
        if (size > MAX_MASK) size = 5'(MAX_MASK);
        if (size == 0) return '0;
        top_val = (32'd1 << size) - 32'd1;
        scaled  = (32'(chan) * top_val) / 32'd255;
        return scaled << pos;
    endfunction

    // returns 1 and the write when enabled, bpp valid and the pixel in the frame
    function automatic bit format_pixel_write(input logic [PIX_X_W-1:0] x,
                                              input logic [PIX_Y_W-1:0] y,
                                              input logic [RGB_W-1:0]   rgb,
                                              output t_frame_write      wr);
        logic [31:0] w_lim, h_lim, p_lim, offset, data;
        logic [7:0]  r, g, b;
        wr    = '0;
        r     = rgb[23:16];
        g     = rgb[15:8];
        b     = rgb[7:0];
        w_lim = (cfg_width  < MAX_WIDTH)  ? 32'(cfg_width)  : 32'(MAX_WIDTH);
        h_lim = (cfg_height < MAX_HEIGHT) ? 32'(cfg_height) : 32'(MAX_HEIGHT);
        p_lim = (cfg_pitch  < MAX_PITCH)  ? 32'(cfg_pitch)  : 32'(MAX_PITCH);
        if (!cfg_enabled || cfg_bpp == 0 || cfg_bpp > 4) return 0;
        if (32'(x) >= w_lim || 32'(y) >= h_lim) return 0;
        offset = 32'(y) * p_lim + 32'(x) * 32'(cfg_bpp);
        if (cfg_bpp == 1) begin
            data = (32'(r) * 30 + 32'(g) * 59 + 32'(b) * 11) / 100;
            if (data > 255) data = 255;
        end else begin
            data = place_channel(r, cfg_red) | place_channel(g, cfg_green)
                 | place_channel(b, cfg_blue);
            if (cfg_bpp < 4) data &= (32'd1 << (8 * cfg_bpp)) - 32'd1;
        end
        wr.byte_offset = offset[OFFSET_W-1:0];
        wr.write_data  = data;
        wr.byte_count  = cfg_bpp;
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (write %0d)",
                 what, seen, wanted, writes_checked);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_enabled = 1'b0;
            cfg_width   = WIDTH_W'(1);
            cfg_height  = HEIGHT_W'(1);
            cfg_pitch   = PITCH_W'(1);
            cfg_bpp     = COUNT_W'(4);
            cfg_red     = LAYOUT_W'(272);
            cfg_green   = LAYOUT_W'(264);
            cfg_blue    = LAYOUT_W'(256);
            expected_writes.delete();
        end else begin
            // outputs first: a write leaving now comes from an older pixel
            if (i_wr.valid && i_wr.ready) begin
                got.byte_offset = i_wr.byte_offset;
                got.write_data  = i_wr.write_data;
                got.byte_count  = i_wr.byte_count;
                if (expected_writes.size() == 0) begin
                    report_mismatch("write with none pending, offset",
                                    32'(got.byte_offset), 32'd0);
                end else begin
                    want = expected_writes.pop_front();
                    if (got.byte_offset !== want.byte_offset)
                        report_mismatch("byte_offset", 32'(got.byte_offset),
                                        32'(want.byte_offset));
                    if (got.write_data !== want.write_data)
                        report_mismatch("write_data", got.write_data, want.write_data);
                    if (got.byte_count !== want.byte_count)
                        report_mismatch("byte_count", 32'(got.byte_count),
                                        32'(want.byte_count));
                    writes_checked++;
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ENABLED:      cfg_enabled = i_cfg_data[0];
                    CFG_FRAME_WIDTH:  cfg_width   = i_cfg_data[WIDTH_W-1:0];
                    CFG_FRAME_HEIGHT: cfg_height  = i_cfg_data[HEIGHT_W-1:0];
                    CFG_LINE_PITCH:   cfg_pitch   = i_cfg_data[PITCH_W-1:0];
                    CFG_BPP:          cfg_bpp     = i_cfg_data[COUNT_W-1:0];
                    CFG_RED_LAYOUT:   cfg_red     = i_cfg_data[LAYOUT_W-1:0];
                    CFG_GREEN_LAYOUT: cfg_green   = i_cfg_data[LAYOUT_W-1:0];
                    CFG_BLUE_LAYOUT:  cfg_blue    = i_cfg_data[LAYOUT_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                if (format_pixel_write(i_pix.pixel_x, i_pix.pixel_y, i_pix.rgb_color, pred))
                    expected_writes.push_back(pred);
            end
        end
        o_pending        <= expected_writes.size();
        o_fail_count     <= fail_count;
        o_writes_checked <= writes_checked;
    end

endmodule

// ===== verif/tb_pixel_write_formatter_core.sv =====
// Top of the pixel write formatter testbench: clock, reset, config writes, pixel
// stimulus and verdict. Depends on pwf_pkg, the channel ifs, the core and pwf_write_checker.
`timescale 1ns / 100ps

module tb_pixel_write_formatter_core;
    import pwf_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 768;
    localparam int MAX_P        = 4096;
    localparam int STALL_LIMIT  = 5000;  // cycles with no item moving on either side
    localparam int LONG_HOLD    = 300;   // receiver hold-off, well past the pipe depth
    localparam int DRAIN_CYCLES = 8;     // pipe is 3 deep, leave some margin
    localparam int PER_SETUP    = 50;    // random items per config setting

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pwf_pixel_if pix_ch ();
    pwf_write_if wr_ch ();

    int src_idle_pct    = 0;
    int sink_stall_pct  = 0;
    bit long_hold_armed = 1'b0;
    int hold_count      = 0;
    int idle_cycles     = 0;
    int items_sent      = 0;
    int cur_w           = 1;  // effective visible area, used to aim random pixels
    int cur_h           = 1;
    int fail_count, pending, writes_checked;

    pixel_write_formatter_core #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H),
        .MAX_PITCH (MAX_P)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_ch),
        .o_wr       (wr_ch)
    );

    pwf_write_checker #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H),
        .MAX_PITCH (MAX_P)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_pix           (pix_ch),
        .i_wr            (wr_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_writes_checked(writes_checked)
    );

    always #1 i_clk = ~i_clk;

    // Receiver: random back-pressure, plus one long hold-off when armed. The
    // hold is counted here so the sender keeps offering and the pipe fills up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_ch.ready <= 1'b0;
        end else if (long_hold_armed && hold_count < LONG_HOLD) begin
            wr_ch.ready <= 1'b0;
            hold_count  <= hold_count + 1;
        end else begin
            wr_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: any item moving on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((pix_ch.valid && pix_ch.ready) || (wr_ch.valid && wr_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: nothing moved for %0d cycles, %0d writes pending",
                     STALL_LIMIT, pending);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one pixel, with random idle cycles ahead of it; returns in the step
    // of the edge that accepted it, valid still high.
    task automatic send_pixel(input logic [PIX_X_W-1:0] x, input logic [PIX_Y_W-1:0] y,
                              input logic [RGB_W-1:0] rgb);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.pixel_x   <= x;
        pix_ch.pixel_y   <= y;
        pix_ch.rgb_color <= rgb;
        do @(posedge i_clk); while (!pix_ch.ready);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted write came out, then let any
    // dropped pixel still in the pipe fall out too.
    task automatic drain();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write; leaves the enable high so back-to-back writes stay clean.
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic program_frame(input logic [CFG_DATA_W-1:0] en, w, h, p, bpp,
                                 input logic [CFG_DATA_W-1:0] red, green, blue);
        int wv, hv;
        cfg_write(CFG_ENABLED,      en);
        cfg_write(CFG_FRAME_WIDTH,  w);
        cfg_write(CFG_FRAME_HEIGHT, h);
        cfg_write(CFG_LINE_PITCH,   p);
        cfg_write(CFG_BPP,          bpp);
        cfg_write(CFG_RED_LAYOUT,   red);
        cfg_write(CFG_GREEN_LAYOUT, green);
        cfg_write(CFG_BLUE_LAYOUT,  blue);
        cfg_we <= 1'b0;
        wv    = int'(w[WIDTH_W-1:0]);
        hv    = int'(h[HEIGHT_W-1:0]);
        cur_w = (wv < MAX_W) ? wv : MAX_W;
        cur_h = (hv < MAX_H) ? hv : MAX_H;
    endtask

    function automatic logic [CFG_DATA_W-1:0] field_layout(input int size, input int pos);
        return CFG_DATA_W'((size << 5) | pos);
    endfunction

    // Sometimes fill the bits above a register's width with noise; the block
    // must ignore them.
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] value,
                                                        input int width);
        logic [CFG_DATA_W-1:0] keep;
        keep = (CFG_DATA_W'(1) << width) - CFG_DATA_W'(1);
        if ($urandom_range(3) == 0)
            return (value & keep) | (CFG_DATA_W'($urandom) & ~keep);
        return value;
    endfunction

    // Random setting; flavor 0 is the largest frame, flavor 4 the smallest.
    task automatic random_frame(input int flavor);
        logic [CFG_DATA_W-1:0] en, w, h, p, bpp;
        logic [CFG_DATA_W-1:0] lay [3];
        int                    k, sel;
        en  = ($urandom_range(9) == 0) ? 13'd0 : 13'd1;
        sel = $urandom_range(9);
        w   = (sel == 0) ? CFG_DATA_W'($urandom_range(0, 2047)) :
              (sel <= 3) ? CFG_DATA_W'($urandom_range(1, 16)) :
                           CFG_DATA_W'($urandom_range(1, MAX_W));
        sel = $urandom_range(9);
        h   = (sel == 0) ? CFG_DATA_W'($urandom_range(0, 1023)) :
              (sel <= 3) ? CFG_DATA_W'($urandom_range(1, 16)) :
                           CFG_DATA_W'($urandom_range(1, MAX_H));
        // pitch above the cap now and then
        p   = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(MAX_P + 1, 8191)) :
                                         CFG_DATA_W'($urandom_range(1, MAX_P));
        if ($urandom_range(9) == 0) begin
            k   = $urandom_range(3);
            bpp = (k == 0) ? 13'd0 : CFG_DATA_W'(4 + k);  // bad pixel sizes
        end else begin
            bpp = CFG_DATA_W'($urandom_range(1, 4));
        end
        for (k = 0; k < 3; k++) begin
            lay[k] = field_layout(($urandom_range(7) == 0) ? $urandom_range(17, 31) :
                                                             $urandom_range(0, 16),
                                  $urandom_range(1) ? $urandom_range(0, 23) :
                                                      $urandom_range(0, 31));
        end
        if (flavor == 0) begin
            en = 13'd1; w = 13'(MAX_W); h = 13'(MAX_H); p = 13'(MAX_P); bpp = 13'd4;
        end else if (flavor == 4) begin
            en = 13'd1; w = 13'd1; h = 13'd1; p = 13'd1;
        end
        program_frame(with_junk(en, 1), with_junk(w, WIDTH_W), with_junk(h, HEIGHT_W),
                      with_junk(p, PITCH_W), with_junk(bpp, COUNT_W),
                      with_junk(lay[0], LAYOUT_W), with_junk(lay[1], LAYOUT_W),
                      with_junk(lay[2], LAYOUT_W));
    endtask

    initial begin
        logic [PIX_X_W-1:0] x;
        logic [PIX_Y_W-1:0] y;
        logic [RGB_W-1:0]   rgb;
        int                 src_pct [4];
        int                 sink_pct[4];
        int                 phase, setup, n;

        // known values on every input from time zero
        pix_ch.valid     = 1'b0;
        pix_ch.pixel_x   = '0;
        pix_ch.pixel_y   = '0;
        pix_ch.rgb_color = '0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;

        // pacing per phase: none, sender idle, receiver stalling, both
        src_pct  = '{0, 75, 0, 30};
        sink_pct = '{0, 0, 75, 30};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // Reset state: disabled, so nothing comes out.
        send_pixel(11'd0, 10'd0, 24'hA5C33C);
        drain();
        // Enable only: reset defaults give a 1x1 frame, 4 bytes, 8:8:8.
        cfg_write(CFG_ENABLED, 13'd1);
        cfg_we <= 1'b0;
        send_pixel(11'd0, 10'd0, 24'h123456);
        send_pixel(11'd1, 10'd0, 24'h654321);  // just past the width
        send_pixel(11'd0, 10'd1, 24'hFFFFFF);  // just past the height
        drain();

        // Largest frame, corners and first pixels outside it.
        program_frame(13'd1, 13'(MAX_W), 13'(MAX_H), 13'(MAX_P), 13'd4,
                      field_layout(8, 16), field_layout(8, 8), field_layout(8, 0));
        send_pixel(11'd0, 10'd0, 24'h000000);
        send_pixel(11'd1023, 10'd767, 24'hFFFFFF);
        send_pixel(11'd1024, 10'd0, 24'h808080);
        send_pixel(11'd0, 10'd768, 24'h808080);
        send_pixel(11'h7FF, 10'h3FF, 24'hFFFFFF);
        drain();

        // Width, height and pitch above their caps, grey luma mode.
        program_frame(13'd2047, 13'd2047, 13'd1023, 13'd8191, 13'd1,
                      field_layout(8, 16), field_layout(8, 8), field_layout(8, 0));
        send_pixel(11'd1023, 10'd767, 24'hFFFFFF);
        send_pixel(11'd512, 10'd100, 24'h808080);
        send_pixel(11'd1500, 10'd0, 24'h112233);
        send_pixel(11'd0, 10'd800, 24'h112233);
        drain();

        // Two bytes, 5:6:5.
        program_frame(13'd1, 13'd64, 13'd64, 13'd200, 13'd2,
                      field_layout(5, 11), field_layout(6, 5), field_layout(5, 0));
        send_pixel(11'd3, 10'd5, 24'hFF8040);
        send_pixel(11'd63, 10'd63, 24'hFFFFFF);
        drain();
        // Three bytes: oversized mask, field spilling past bit 31, zero-size mask.
        program_frame(13'd1, 13'd64, 13'd64, 13'd200, 13'd3,
                      field_layout(31, 16), field_layout(16, 31), field_layout(0, 0));
        send_pixel(11'd1, 10'd1, 24'hFFFFFF);
        send_pixel(11'd2, 10'd2, 24'h7F80FF);
        drain();

        // Bad pixel sizes drop every write.
        program_frame(13'd1, 13'd64, 13'd64, 13'd64, 13'd0,
                      field_layout(8, 16), field_layout(8, 8), field_layout(8, 0));
        send_pixel(11'd0, 10'd0, 24'h010203);
        drain();
        program_frame(13'd1, 13'd64, 13'd64, 13'd64, 13'd5,
                      field_layout(8, 16), field_layout(8, 8), field_layout(8, 0));
        send_pixel(11'd0, 10'd0, 24'h010203);
        drain();
        program_frame(13'd1, 13'd64, 13'd64, 13'd64, 13'd7,
                      field_layout(8, 16), field_layout(8, 8), field_layout(8, 0));
        send_pixel(11'd0, 10'd0, 24'h010203);
        drain();

        // Zero width, then zero height: nothing is visible.
        program_frame(13'd1, 13'd0, 13'd64, 13'd64, 13'd4,
                      field_layout(8, 16), field_layout(8, 8), field_layout(8, 0));
        send_pixel(11'd0, 10'd0, 24'hABCDEF);
        drain();
        program_frame(13'd1, 13'd64, 13'd0, 13'd64, 13'd4,
                      field_layout(8, 16), field_layout(8, 8), field_layout(8, 0));
        send_pixel(11'd0, 10'd0, 24'hABCDEF);
        drain();

        // ---- random part ----
        for (phase = 0; phase < 4; phase++) begin
            src_idle_pct    = src_pct[phase];
            sink_stall_pct <= sink_pct[phase];
            for (setup = 0; setup < 3; setup++) begin
                random_frame(phase * 3 + setup);
                // First setting: receiver holds off while the sender keeps going.
                if (phase == 0 && setup == 0) long_hold_armed <= 1'b1;
                for (n = 0; n < PER_SETUP; n++) begin
                    // mostly inside the visible area, the rest anywhere
                    if ($urandom_range(4) != 0 && cur_w > 0 && cur_h > 0) begin
                        x = PIX_X_W'($urandom_range(0, cur_w - 1));
                        y = PIX_Y_W'($urandom_range(0, cur_h - 1));
                    end else begin
                        x = PIX_X_W'($urandom);
                        y = PIX_Y_W'($urandom);
                    end
                    case ($urandom_range(7))
                        0:       rgb = 24'h000000;
                        1:       rgb = 24'hFFFFFF;
                        2:       rgb = {($urandom_range(1) ? 8'hFF : 8'h00),
                                        ($urandom_range(1) ? 8'hFF : 8'h00),
                                        ($urandom_range(1) ? 8'hFF : 8'h00)};
                        default: rgb = RGB_W'($urandom);
                    endcase
                    send_pixel(x, y, rgb);
                end
                drain();
            end
        end

        $display("Summary: %0d pixel writes offered, %0d frame-store writes checked, %0d dropped",
                 items_sent, writes_checked, items_sent - writes_checked);
        $display("Summary: 1-4 bytes/pixel, luma, bad sizes, clipping, caps, four pacing modes");
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pwf_pkg.sv
rtl/core/pwf_pixel_if.sv
rtl/core/pwf_write_if.sv
rtl/core/pixel_write_formatter_core.sv
verif/pwf_write_checker.sv
verif/tb_pixel_write_formatter_core.sv
